// ----- hw/rtl/tepf_pkg.sv -----
// Shared types and constants for the threshold excursion peak finder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tepf_pkg;

    localparam int SAMPLE_W       = 13;
    localparam int INDEX_W        = 16;
    localparam int COUNT_W        = 16;
    localparam int MAX_CROSSINGS  = 256;
    localparam int MAX_RECORD_LEN = 65536;
    localparam int CROSS_W        = $clog2(MAX_CROSSINGS + 2);
    localparam int INDEX_LIMIT_I  = (MAX_RECORD_LEN > 65536) ? 65535 : MAX_RECORD_LEN - 1;

    localparam logic [INDEX_W-1:0]  INDEX_LIMIT      = INDEX_W'(INDEX_LIMIT_I);
    localparam logic [COUNT_W-1:0]  COUNT_MAX        = '1;
    localparam logic [CROSS_W-1:0]  CROSS_LIMIT      = CROSS_W'(MAX_CROSSINGS);
    localparam logic [SAMPLE_W-1:0] LOWER_PEAK_START = SAMPLE_W'(5000);

    localparam logic [SAMPLE_W-1:0] UPPER_RESET = SAMPLE_W'(2500);
    localparam logic [SAMPLE_W-1:0] LOWER_RESET = SAMPLE_W'(600);
    localparam logic [COUNT_W-1:0]  MINPT_RESET = '0;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_UPPER_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOWER_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_POINTS      = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW    = $clog2(FIFO_DEPTH + 1);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    typedef struct packed {
        logic [SAMPLE_W-1:0] upper_threshold;
        logic [SAMPLE_W-1:0] lower_threshold;
        logic [COUNT_W-1:0]  min_points;
    } tepf_cfg_t;

    typedef struct packed {
        logic up_open;
        logic up_close;
        logic lo_open;
        logic lo_close;
        logic p_above_u;
        logic c_above_u;
        logic p_below_l;
        logic c_below_l;
    } tepf_flags_t;

    typedef struct packed {
        logic                rec_start;
        logic [SAMPLE_W-1:0] smp;
        logic [SAMPLE_W-1:0] prev;
        logic [INDEX_W-1:0]  base_idx;
        tepf_flags_t         flags;
    } tepf_item_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [FIFO_LW-1:0] level;
    } tepf_fifo_stat_t;

    typedef struct packed {
        logic                upper_open;
        logic                lower_open;
        logic [CROSS_W-1:0]  cross_count;
    } tepf_back_stat_t;

    typedef struct packed {
        logic                polarity;
        logic [INDEX_W-1:0]  start_index;
        logic [INDEX_W-1:0]  end_index;
        logic [SAMPLE_W-1:0] peak_value;
    } tepf_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tepf_front.sv -----
// Front end: accepts samples, tracks record index and previous sample,
// classifies threshold crossings. Depends on tepf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tepf_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tepf_pkg::tepf_cfg_t           cfg,
    input  wire logic                          in_valid,
    input  wire logic [tepf_pkg::SAMPLE_W-1:0] in_sample,
    input  wire logic                          in_rec_start,
    input  wire logic                          q_full,
    output logic                               in_ready,
    output logic                               q_push,
    output tepf_pkg::tepf_item_t               q_item
);
    import tepf_pkg::*;

    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic                have_prev_reg, have_prev_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic                accept;
    logic                start;
    logic [SAMPLE_W-1:0] u, l, c, p;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign start    = in_rec_start || !have_prev_reg;
    assign u        = cfg.upper_threshold;
    assign l        = cfg.lower_threshold;
    assign c        = in_sample;
    assign p        = prev_reg;

    always_comb begin
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        index_next     = index_reg;
        q_push         = 1'b0;
        if (accept) begin
            if (start) begin
                prev_next      = c;
                have_prev_next = 1'b1;
                index_next     = '0;
                q_push         = 1'b1;
            end else if (index_reg < INDEX_LIMIT) begin
                prev_next  = c;
                index_next = index_reg + INDEX_W'(1);
                q_push     = 1'b1;
            end
        end
    end

    always_comb begin
        q_item                 = '0;
        q_item.rec_start       = start;
        q_item.smp             = c;
        q_item.prev            = p;
        q_item.base_idx        = index_reg;
        q_item.flags.up_open   = (p < u) && (c >= u);
        q_item.flags.up_close  = (p >= u) && (c < u);
        q_item.flags.lo_open   = (p > l) && (c <= l);
        q_item.flags.lo_close  = (p <= l) && (c > l);
        q_item.flags.p_above_u = p > u;
        q_item.flags.c_above_u = c > u;
        q_item.flags.p_below_l = p < l;
        q_item.flags.c_below_l = c < l;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            index_reg     <= '0;
        end else begin
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            index_reg     <= index_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tepf_fifo.sv -----
// Short request queue between front and back ends, flip-flop storage.
// Depends on tepf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tepf_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire tepf_pkg::tepf_item_t push_item,
    input  wire logic                 pop,
    output tepf_pkg::tepf_item_t      pop_item,
    output tepf_pkg::tepf_fifo_stat_t stat
);
    import tepf_pkg::*;

    tepf_item_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LW-1:0]  level_reg, level_next;
    logic                do_push, do_pop;

    assign stat.full  = level_reg == FIFO_LW'(FIFO_DEPTH);
    assign stat.empty = level_reg == '0;
    assign stat.level = level_reg;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + FIFO_AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + FIFO_AW'(1);
        end
        if (do_push && !do_pop) begin
            level_next = level_reg + FIFO_LW'(1);
        end else if (do_pop && !do_push) begin
            level_next = level_reg - FIFO_LW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tepf_back.sv -----
// Back end: excursion state, point count, running peak, crossing limit and
// the result output register. Depends on tepf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tepf_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tepf_pkg::tepf_cfg_t  cfg,
    input  wire logic                 q_empty,
    input  wire tepf_pkg::tepf_item_t q_item,
    output logic                      q_pop,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output tepf_pkg::tepf_result_t    res,
    output tepf_pkg::tepf_back_stat_t stat
);
    import tepf_pkg::*;

    logic                uo_reg, uo_next;
    logic                lo_reg, lo_next;
    logic [INDEX_W-1:0]  oi_reg, oi_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] pk_reg, pk_next;
    logic [CROSS_W-1:0]  cc_reg, cc_next;
    logic                out_valid_reg, out_valid_next;
    tepf_result_t        out_reg, out_next;

    logic                out_ready;
    logic                emit;
    logic                closing;
    logic [COUNT_W-1:0]  cnt_a;
    logic [SAMPLE_W-1:0] pk_a;
    logic [SAMPLE_W-1:0] hi_pc, lo_pc;
    tepf_flags_t         f;
    logic [SAMPLE_W-1:0] c, p;

    assign out_ready = !out_valid_reg || res_ready;
    assign q_pop     = !q_empty && out_ready;
    assign f         = q_item.flags;
    assign c         = q_item.smp;
    assign p         = q_item.prev;
    assign hi_pc     = (c > p) ? c : p;
    assign lo_pc     = (c < p) ? c : p;

    always_comb begin
        cnt_a = cnt_reg;
        pk_a  = pk_reg;
        if (uo_reg) begin
            if (f.c_above_u && cnt_reg != COUNT_MAX) begin
                cnt_a = cnt_reg + COUNT_W'(1);
            end
            if (c > pk_reg) begin
                pk_a = c;
            end
        end else if (lo_reg) begin
            if (f.c_below_l && cnt_reg != COUNT_MAX) begin
                cnt_a = cnt_reg + COUNT_W'(1);
            end
            if (c < pk_reg) begin
                pk_a = c;
            end
        end
    end

    assign closing = (uo_reg && f.up_close) || (lo_reg && f.lo_close);

    always_comb begin
        uo_next  = uo_reg;
        lo_next  = lo_reg;
        oi_next  = oi_reg;
        cnt_next = cnt_reg;
        pk_next  = pk_reg;
        cc_next  = cc_reg;
        emit     = 1'b0;
        out_next = out_reg;
        if (q_pop) begin
            if (q_item.rec_start) begin
                uo_next  = 1'b0;
                lo_next  = 1'b0;
                oi_next  = '0;
                cnt_next = '0;
                pk_next  = '0;
                cc_next  = '0;
            end else if (cc_reg < CROSS_LIMIT) begin
                cnt_next = cnt_a;
                pk_next  = pk_a;
                if (closing) begin
                    emit                 = cnt_a > cfg.min_points;
                    out_next.polarity    = uo_reg;
                    out_next.start_index = oi_reg;
                    out_next.end_index   = q_item.base_idx + INDEX_W'(1);
                    out_next.peak_value  = pk_a;
                    uo_next              = 1'b0;
                    lo_next              = 1'b0;
                    cc_next              = cc_reg + CROSS_W'(1);
                end
                if (closing || (!uo_reg && !lo_reg)) begin
                    if (f.up_open) begin
                        uo_next  = 1'b1;
                        lo_next  = 1'b0;
                        oi_next  = q_item.base_idx;
                        cnt_next = COUNT_W'(f.p_above_u) + COUNT_W'(f.c_above_u);
                        pk_next  = hi_pc;
                        cc_next  = cc_reg + (closing ? CROSS_W'(2) : CROSS_W'(1));
                    end else if (f.lo_open) begin
                        uo_next  = 1'b0;
                        lo_next  = 1'b1;
                        oi_next  = q_item.base_idx;
                        cnt_next = COUNT_W'(f.p_below_l) + COUNT_W'(f.c_below_l);
                        pk_next  = (lo_pc < LOWER_PEAK_START) ? lo_pc : LOWER_PEAK_START;
                        cc_next  = cc_reg + (closing ? CROSS_W'(2) : CROSS_W'(1));
                    end
                end
            end
        end
        out_valid_next = out_ready ? emit : out_valid_reg;
        if (!emit) begin
            out_next = out_reg;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        oi_reg  <= oi_next;
        cnt_reg <= cnt_next;
        pk_reg  <= pk_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uo_reg        <= 1'b0;
            lo_reg        <= 1'b0;
            cc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            uo_reg        <= uo_next;
            lo_reg        <= lo_next;
            cc_reg        <= cc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid        = out_valid_reg;
    assign res              = out_reg;
    assign stat.upper_open  = uo_reg;
    assign stat.lower_open  = lo_reg;
    assign stat.cross_count = cc_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/threshold_excursion_peak_finder_core.sv -----
// Top level of the threshold excursion peak finder: configuration registers,
// front end, request queue and back end. Depends on tepf_pkg, tepf_front,
// tepf_fifo and tepf_back.
//
//   channel  direction  handshake          payload
//   s_       in         s_tvalid/s_tready  s_tdata: sample; s_tuser: record_start
//   m_       out        m_tvalid/m_tready  m_tdata: start/end index, peak; m_tuser: polarity
//   cfg_     in         cfg_wr_en          cfg_addr, cfg_wr_data
//
// One sample per cycle sustained while the queue has room. A sample's result passes
// through the queue entry and then the output register: the front classifies in the
// accepting cycle and writes the queue, the back pops the request once the output register is free and loads it.
// s_tready drops only while the four-entry queue is full; the back holds the queue
// while a result waits in the output register and m_tready is low.
// Reset (synchronous, aresetn low) restores the register defaults and clears the open
// flags, crossing count, output valid and the front's index and previous sample; no clearing pass follows.
`timescale 1ns / 1ps
`default_nettype none

module threshold_excursion_peak_finder_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tepf_pkg::S_TDATA_W-1:0]    s_tdata,     // [12:0] sample
    input  wire logic                              s_tuser,     // [0] record_start
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tepf_pkg::M_TDATA_W-1:0]         m_tdata,     // [15:0] start_index,
                                                                // [31:16] end_index,
                                                                // [44:32] peak_value
    output logic                                   m_tuser,     // [0] polarity
    input  wire logic                              cfg_wr_en,
    input  wire logic [tepf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [tepf_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import tepf_pkg::*;

    tepf_cfg_t       cfg_reg, cfg_next;
    logic            q_push;
    tepf_item_t      push_item;
    tepf_item_t      pop_item;
    logic            q_pop;
    tepf_fifo_stat_t fifo_stat;
    tepf_back_stat_t back_stat;
    tepf_result_t    res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_UPPER_THRESHOLD: cfg_next.upper_threshold = cfg_wr_data[SAMPLE_W-1:0];
                REG_LOWER_THRESHOLD: cfg_next.lower_threshold = cfg_wr_data[SAMPLE_W-1:0];
                REG_MIN_POINTS:      cfg_next.min_points      = cfg_wr_data[COUNT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.upper_threshold <= UPPER_RESET;
            cfg_reg.lower_threshold <= LOWER_RESET;
            cfg_reg.min_points      <= MINPT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tepf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_sample    (s_tdata[SAMPLE_W-1:0]),
        .in_rec_start (s_tuser),
        .q_full       (fifo_stat.full),
        .in_ready     (s_tready),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    tepf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .stat      (fifo_stat)
    );

    tepf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_empty   (fifo_stat.empty),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res),
        .stat      (back_stat)
    );

    assign m_tuser = res.polarity;
    assign m_tdata = {3'b000, res.peak_value, res.end_index, res.start_index};

    a_one_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !(back_stat.upper_open && back_stat.lower_open))
        else $error("upper and lower excursion open together");

    a_fifo_level: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_stat.level <= FIFO_LW'(FIFO_DEPTH))
        else $error("request queue level out of range");

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:16] > m_tdata[15:0]))
        else $error("result end index not after start index");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(q_pop))
        else $error("result without a dequeued request");

    a_cross_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.cross_count <= CROSS_W'(MAX_CROSSINGS + 1))
        else $error("crossing count beyond limit");

endmodule

`default_nettype wire
